// ===== design/ipwm_pkg.sv =====
package ipwm_pkg;

   // stream word widths
   localparam int IN_W     = 20;
   localparam int PERIOD_W = 21;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 72;
   localparam int RSP_PAD  = 7;

   // result field widths
   localparam int STATUS_W = 4;
   localparam int FREQ_W   = 27;
   localparam int DUTY_W   = 14;
   localparam int RES_W    = 20;

   // datapath widths: operand registers and divider
   localparam int K_W      = 27;
   localparam int PROD_W   = 48;
   localparam int DIV_W    = 38;
   localparam int CNT_W    = 6;
   localparam int PC_W     = 6;
   localparam int FLAG_W   = 5;
   localparam int NUM_FLAGS = 17;

   localparam logic [RES_W-1:0] RES_MAX = '1;
   localparam logic [PC_W-1:0]  END_PC  = 6'd49;

   // status codes
   localparam logic [STATUS_W-1:0] ST_NORMAL          = 4'd0;
   localparam logic [STATUS_W-1:0] ST_NORMAL_BAD_DUTY = 4'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERVOLT       = 4'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERVOLT_BAD   = 4'd3;
   localparam logic [STATUS_W-1:0] ST_START_GOOD      = 4'd4;
   localparam logic [STATUS_W-1:0] ST_START_BAD       = 4'd5;
   localparam logic [STATUS_W-1:0] ST_START_BAD_DUTY  = 4'd6;
   localparam logic [STATUS_W-1:0] ST_DEVICE_ERR      = 4'd7;
   localparam logic [STATUS_W-1:0] ST_DEVICE_ERR_BAD  = 4'd8;
   localparam logic [STATUS_W-1:0] ST_EARTH_FAULT     = 4'd9;
   localparam logic [STATUS_W-1:0] ST_EARTH_FAULT_BAD = 4'd10;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH        = 4'd11;
   localparam logic [STATUS_W-1:0] ST_NO_SIGNAL       = 4'd12;

   // flag register slots
   localparam logic [FLAG_W-1:0] FL_LO10   = 5'd0;
   localparam logic [FLAG_W-1:0] FL_LO20   = 5'd1;
   localparam logic [FLAG_W-1:0] FL_LO30   = 5'd2;
   localparam logic [FLAG_W-1:0] FL_LO40   = 5'd3;
   localparam logic [FLAG_W-1:0] FL_LO50   = 5'd4;
   localparam logic [FLAG_W-1:0] FL_HI10   = 5'd5;
   localparam logic [FLAG_W-1:0] FL_HI20   = 5'd6;
   localparam logic [FLAG_W-1:0] FL_HI30   = 5'd7;
   localparam logic [FLAG_W-1:0] FL_HI40   = 5'd8;
   localparam logic [FLAG_W-1:0] FL_HI50   = 5'd9;
   localparam logic [FLAG_W-1:0] FL_W_GE   = 5'd10;
   localparam logic [FLAG_W-1:0] FL_W_LE   = 5'd11;
   localparam logic [FLAG_W-1:0] FL_L_LE   = 5'd12;
   localparam logic [FLAG_W-1:0] FL_H_GE   = 5'd13;
   localparam logic [FLAG_W-1:0] FL_M_GE   = 5'd14;
   localparam logic [FLAG_W-1:0] FL_M_LE   = 5'd15;
   localparam logic [FLAG_W-1:0] FL_NONPOS = 5'd16;

   typedef enum logic [2:0] {
      OP_MUL_A, OP_MUL_B, OP_CMP, OP_SUB, OP_DIV, OP_JMP, OP_END
   } op_type;

   typedef enum logic [1:0] {SRC_ONE, SRC_H, SRC_P} src_type;
   typedef enum logic       {CMP_LE, CMP_GE} cmp_type;
   typedef enum logic       {COND_PZERO, COND_NONPOS} cond_type;
   typedef enum logic [1:0] {DST_FREQ, DST_DUTY, DST_RES} dst_type;

   // one microcode word
   typedef struct packed {
      op_type            op;
      src_type           src;
      logic [K_W-1:0]    k;
      cmp_type           cmp;
      logic [FLAG_W-1:0] flag;
      cond_type          cond;
      logic [PC_W-1:0]   target;
      dst_type           dst;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      logic      run;
      ucode_type uw;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic div_done;
      logic pzero;
      logic nonpos;
   } fb_type;

   // datapath results for the output word
   typedef struct packed {
      logic [NUM_FLAGS-1:0] flags;
      logic [FREQ_W-1:0]    freq;
      logic [DUTY_W-1:0]    duty;
      logic [RES_W-1:0]     res;
      logic                 pzero;
   } dp_res_type;

   function automatic ucode_type uc_mul(op_type op, logic [K_W-1:0] k, src_type src);
      ucode_type w;
      w = '0;
      w.op = op;
      w.k = k;
      w.src = src;
      return w;
   endfunction

   function automatic ucode_type uc_cmp(cmp_type c, logic [FLAG_W-1:0] f);
      ucode_type w;
      w = '0;
      w.op = OP_CMP;
      w.cmp = c;
      w.flag = f;
      return w;
   endfunction

   function automatic ucode_type uc_jmp(cond_type c, logic [PC_W-1:0] t);
      ucode_type w;
      w = '0;
      w.op = OP_JMP;
      w.cond = c;
      w.target = t;
      return w;
   endfunction

   function automatic ucode_type uc_div(dst_type d);
      ucode_type w;
      w = '0;
      w.op = OP_DIV;
      w.dst = d;
      return w;
   endfunction

   function automatic ucode_type uc_op(op_type op);
      ucode_type w;
      w = '0;
      w.op = op;
      return w;
   endfunction

   // control store: band tests, duty windows, three divides
   function automatic ucode_type ipwm_ucode(logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         6'd0:  w = uc_jmp(COND_PZERO, END_PC);
         6'd1:  w = uc_mul(OP_MUL_B, 27'd10_000_000, SRC_ONE);
         // 10 hz band: 90p <= 1e7 <= 110p
         6'd2:  w = uc_mul(OP_MUL_A, 27'd90, SRC_P);
         6'd3:  w = uc_cmp(CMP_LE, FL_LO10);
         6'd4:  w = uc_mul(OP_MUL_A, 27'd110, SRC_P);
         6'd5:  w = uc_cmp(CMP_GE, FL_HI10);
         // 20 hz band
         6'd6:  w = uc_mul(OP_MUL_A, 27'd180, SRC_P);
         6'd7:  w = uc_cmp(CMP_LE, FL_LO20);
         6'd8:  w = uc_mul(OP_MUL_A, 27'd220, SRC_P);
         6'd9:  w = uc_cmp(CMP_GE, FL_HI20);
         // 30 hz band
         6'd10: w = uc_mul(OP_MUL_A, 27'd270, SRC_P);
         6'd11: w = uc_cmp(CMP_LE, FL_LO30);
         6'd12: w = uc_mul(OP_MUL_A, 27'd330, SRC_P);
         6'd13: w = uc_cmp(CMP_GE, FL_HI30);
         // 40 hz band
         6'd14: w = uc_mul(OP_MUL_A, 27'd360, SRC_P);
         6'd15: w = uc_cmp(CMP_LE, FL_LO40);
         6'd16: w = uc_mul(OP_MUL_A, 27'd440, SRC_P);
         6'd17: w = uc_cmp(CMP_GE, FL_HI40);
         // 50 hz band
         6'd18: w = uc_mul(OP_MUL_A, 27'd450, SRC_P);
         6'd19: w = uc_cmp(CMP_LE, FL_LO50);
         6'd20: w = uc_mul(OP_MUL_A, 27'd550, SRC_P);
         6'd21: w = uc_cmp(CMP_GE, FL_HI50);
         // half-percent duty windows against 200h
         6'd22: w = uc_mul(OP_MUL_A, 27'd200, SRC_H);
         6'd23: w = uc_mul(OP_MUL_B, 27'd9, SRC_P);
         6'd24: w = uc_cmp(CMP_GE, FL_W_GE);
         6'd25: w = uc_mul(OP_MUL_B, 27'd191, SRC_P);
         6'd26: w = uc_cmp(CMP_LE, FL_W_LE);
         6'd27: w = uc_mul(OP_MUL_B, 27'd21, SRC_P);
         6'd28: w = uc_cmp(CMP_LE, FL_L_LE);
         6'd29: w = uc_mul(OP_MUL_B, 27'd179, SRC_P);
         6'd30: w = uc_cmp(CMP_GE, FL_H_GE);
         // whole-percent windows against 100h
         6'd31: w = uc_mul(OP_MUL_A, 27'd100, SRC_H);
         6'd32: w = uc_mul(OP_MUL_B, 27'd47, SRC_P);
         6'd33: w = uc_cmp(CMP_GE, FL_M_GE);
         6'd34: w = uc_mul(OP_MUL_B, 27'd53, SRC_P);
         6'd35: w = uc_cmp(CMP_LE, FL_M_LE);
         // frequency and duty
         6'd36: w = uc_mul(OP_MUL_A, 27'd100_000_000, SRC_ONE);
         6'd37: w = uc_mul(OP_MUL_B, 27'd1, SRC_P);
         6'd38: w = uc_div(DST_FREQ);
         6'd39: w = uc_mul(OP_MUL_A, 27'd10_000, SRC_H);
         6'd40: w = uc_mul(OP_MUL_B, 27'd1, SRC_P);
         6'd41: w = uc_div(DST_DUTY);
         // resistance, skipped when denominator is not positive
         6'd42: w = uc_mul(OP_MUL_A, 27'd100, SRC_H);
         6'd43: w = uc_mul(OP_MUL_B, 27'd5, SRC_P);
         6'd44: w = uc_cmp(CMP_LE, FL_NONPOS);
         6'd45: w = uc_jmp(COND_NONPOS, END_PC);
         6'd46: w = uc_op(OP_SUB);
         6'd47: w = uc_mul(OP_MUL_A, 27'd108_000, SRC_P);
         6'd48: w = uc_div(DST_RES);
         default: w = uc_op(OP_END);
      endcase
      return w;
   endfunction

   // status from the band and window flags
   function automatic logic [STATUS_W-1:0] ipwm_status(logic [NUM_FLAGS-1:0] f);
      logic wide, lo_win, hi_win, mid;
      logic [STATUS_W-1:0] st;
      wide   = f[FL_W_GE] & f[FL_W_LE];
      lo_win = f[FL_W_GE] & f[FL_L_LE];
      hi_win = f[FL_H_GE] & f[FL_W_LE];
      mid    = f[FL_M_GE] & f[FL_M_LE];
      if (f[FL_LO10] & f[FL_HI10]) begin
         st = wide ? ST_NORMAL : ST_NORMAL_BAD_DUTY;
      end else if (f[FL_LO20] & f[FL_HI20]) begin
         st = wide ? ST_UNDERVOLT : ST_UNDERVOLT_BAD;
      end else if (f[FL_LO30] & f[FL_HI30]) begin
         st = lo_win ? ST_START_GOOD : (hi_win ? ST_START_BAD : ST_START_BAD_DUTY);
      end else if (f[FL_LO40] & f[FL_HI40]) begin
         st = mid ? ST_DEVICE_ERR : ST_DEVICE_ERR_BAD;
      end else if (f[FL_LO50] & f[FL_HI50]) begin
         st = mid ? ST_EARTH_FAULT : ST_EARTH_FAULT_BAD;
      end else begin
         st = ST_NO_MATCH;
      end
      return st;
   endfunction

   // statuses that carry a resistance
   function automatic logic ipwm_res_valid(logic [STATUS_W-1:0] st);
      logic v;
      case (st) inside
         ST_NORMAL, ST_UNDERVOLT, ST_START_GOOD, ST_START_BAD, ST_DEVICE_ERR: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/ipwm_divider.sv =====
module ipwm_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req,
   input  logic [ipwm_pkg::DIV_W-1:0]  dividend,
   input  logic [ipwm_pkg::DIV_W-1:0]  divisor,
   output logic [ipwm_pkg::DIV_W-1:0]  quotient,
   output logic                        done
);
   import ipwm_pkg::*;

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_state_type;

   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIV_W - 1);

   dv_state_type       state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;
   logic               ge;

   // one restoring step: bring down next dividend bit
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (req) begin
               state_in = DV_RUN;
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = dividend;
               dsr_in   = divisor;
            end
         end
         DV_RUN: begin
            rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = (state_ff == DV_DONE);

endmodule

// ===== design/ipwm_datapath.sv =====
module ipwm_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [ipwm_pkg::IN_W-1:0]      high,
   input  logic [ipwm_pkg::PERIOD_W-1:0]  period,
   input  ipwm_pkg::ctrl_type             ctrl,
   output ipwm_pkg::fb_type               fb,
   output ipwm_pkg::dp_res_type           dp_res
);
   import ipwm_pkg::*;

   logic [IN_W-1:0]      h_ff, h_in;
   logic [PERIOD_W-1:0]  p_ff, p_in;
   logic [DIV_W-1:0]     a_ff, a_in;
   logic [DIV_W-1:0]     b_ff, b_in;
   logic [NUM_FLAGS-1:0] flags_ff, flags_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;
   logic [RES_W-1:0]     res_ff, res_in;

   logic [PERIOD_W-1:0]  opnd;
   logic [PROD_W-1:0]    prod;
   logic                 cmp_bit;
   logic                 div_req;
   logic [DIV_W-1:0]     quo;
   logic                 div_done;
   logic [RES_W-1:0]     res_sat;

   // multiplier operand select
   always_comb begin
      unique case (ctrl.uw.src)
         SRC_ONE: opnd = PERIOD_W'(1);
         SRC_H:   opnd = {1'b0, h_ff};
         SRC_P:   opnd = p_ff;
         default: opnd = '0;
      endcase
   end

   // constant times operand, registered into a or b
   assign prod = ctrl.uw.k * opnd;

   // comparator
   assign cmp_bit = (ctrl.uw.cmp == CMP_LE) ? (a_ff <= b_ff) : (a_ff >= b_ff);

   // shared divider: dividend in a, divisor in b
   assign div_req = ctrl.run && (ctrl.uw.op == OP_DIV);

   ipwm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (a_ff),
      .divisor  (b_ff),
      .quotient (quo),
      .done     (div_done)
   );

   assign res_sat = (quo > DIV_W'(RES_MAX)) ? RES_MAX : quo[RES_W-1:0];

   // execute one control word
   always_comb begin
      h_in     = h_ff;
      p_in     = p_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      flags_in = flags_ff;
      freq_in  = freq_ff;
      duty_in  = duty_ff;
      res_in   = res_ff;
      if (load) begin
         h_in = high;
         p_in = period;
      end
      if (ctrl.run) begin
         unique case (ctrl.uw.op)
            OP_MUL_A: a_in = prod[DIV_W-1:0];
            OP_MUL_B: b_in = prod[DIV_W-1:0];
            OP_CMP:   flags_in[ctrl.uw.flag] = cmp_bit;
            OP_SUB:   b_in = a_ff - b_ff;
            OP_DIV: begin
               if (div_done) begin
                  unique case (ctrl.uw.dst)
                     DST_FREQ: freq_in = quo[FREQ_W-1:0];
                     DST_DUTY: duty_in = quo[DUTY_W-1:0];
                     DST_RES:  res_in  = res_sat;
                     default:  res_in  = res_ff;
                  endcase
               end
            end
            OP_JMP, OP_END: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      p_ff     <= p_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      flags_ff <= flags_in;
      freq_ff  <= freq_in;
      duty_ff  <= duty_in;
      res_ff   <= res_in;
   end

   // status back to the sequencer
   assign fb.div_done = div_done;
   assign fb.pzero    = (p_ff == '0);
   assign fb.nonpos   = flags_ff[FL_NONPOS];

   assign dp_res.flags = flags_ff;
   assign dp_res.freq  = freq_ff;
   assign dp_res.duty  = duty_ff;
   assign dp_res.res   = res_ff;
   assign dp_res.pzero = (p_ff == '0);

endmodule

// ===== design/ipwm_sequencer.sv =====
module ipwm_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_free,
   input  ipwm_pkg::fb_type     fb,
   output ipwm_pkg::ctrl_type   ctrl,
   output logic                 busy,
   output logic                 fin
);
   import ipwm_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            run_ff, run_in;
   ucode_type       uw;
   logic            taken;

   // fetch
   assign uw = ipwm_ucode(pc_ff);

   // jump condition
   always_comb begin
      unique case (uw.cond)
         COND_PZERO:  taken = fb.pzero;
         COND_NONPOS: taken = fb.nonpos;
         default:     taken = 1'b0;
      endcase
   end

   // step counter and program control
   always_comb begin
      pc_in  = pc_ff;
      run_in = run_ff;
      fin    = 1'b0;
      if (start) begin
         run_in = 1'b1;
         pc_in  = '0;
      end else if (run_ff) begin
         unique case (uw.op)
            OP_JMP: pc_in = taken ? uw.target : pc_ff + 1'b1;
            OP_DIV: begin
               if (fb.div_done) begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            OP_END: begin
               if (out_free) begin
                  run_in = 1'b0;
                  fin    = 1'b1;
               end
            end
            default: pc_in = pc_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pc_ff  <= '0;
      end else begin
         run_ff <= run_in;
         pc_ff  <= pc_in;
      end
   end

   assign ctrl.run = run_ff;
   assign ctrl.uw  = uw;
   assign busy     = run_ff;

endmodule

// ===== design/insulation_monitor_pwm_decoder_top.sv =====
// program: a new period runs a 50-step control program, which skips the resistance
// divide when duty is at or below 5% and jumps to its end step when the period is zero
// throughput: one word per program run, set by up to three passes of the shared
// restoring divider plus the multiply and compare steps; no new period is taken while it runs
// a repeated period is accepted and gives no result
// reset: synchronous, clears the sequencer, divider, output valid and last period
module insulation_monitor_pwm_decoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [19:0] high_us, [39:20] low_us
   input  logic [ipwm_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [3:0] status, [30:4] freq_centihz, [44:31] duty_centipct,
   // [64:45] resistance_kohm, [71:65] zero
   output logic [ipwm_pkg::RSP_W-1:0]  rsp_tdata,
   // [0] resistance_valid
   output logic [0:0]                  rsp_tuser
);
   import ipwm_pkg::*;

   logic [IN_W-1:0]     high;
   logic [IN_W-1:0]     low;
   logic [PERIOD_W-1:0] period;
   logic                accept;
   logic                rep_hit;
   logic                start;
   logic                busy;
   logic                fin;
   logic                out_free;
   ctrl_type            ctrl;
   fb_type              fb;
   dp_res_type          dp_res;

   logic [PERIOD_W-1:0] last_period_ff, last_period_in;
   logic                have_last_ff, have_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FREQ_W-1:0]   rsp_freq_ff, rsp_freq_in;
   logic [DUTY_W-1:0]   rsp_duty_ff, rsp_duty_in;
   logic [RES_W-1:0]    rsp_res_ff, rsp_res_in;
   logic                rsp_rv_ff, rsp_rv_in;
   logic [STATUS_W-1:0] status;
   logic                rv;

   // input word and period
   assign high   = req_tdata[IN_W-1:0];
   assign low    = req_tdata[2*IN_W-1:IN_W];
   assign period = {1'b0, high} + {1'b0, low};

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign rep_hit    = have_last_ff && (period == last_period_ff);
   assign start      = accept && !rep_hit;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   ipwm_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .fb       (fb),
      .ctrl     (ctrl),
      .busy     (busy),
      .fin      (fin)
   );

   ipwm_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .load   (start),
      .high   (high),
      .period (period),
      .ctrl   (ctrl),
      .fb     (fb),
      .dp_res (dp_res)
   );

   // result fields at the end of the program
   assign status = dp_res.pzero ? ST_NO_SIGNAL : ipwm_status(dp_res.flags);
   assign rv     = !dp_res.pzero && ipwm_res_valid(status);

   // last reported period
   always_comb begin
      last_period_in = last_period_ff;
      have_last_in   = have_last_ff;
      if (start) begin
         last_period_in = period;
         have_last_in   = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_rv_in     = rsp_rv_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_freq_in   = dp_res.pzero ? '0 : dp_res.freq;
         rsp_duty_in   = dp_res.pzero ? '0 : dp_res.duty;
         rsp_rv_in     = rv;
         if (!rv) begin
            rsp_res_in = '0;
         end else if (dp_res.flags[FL_NONPOS]) begin
            rsp_res_in = RES_MAX;
         end else begin
            rsp_res_in = dp_res.res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_period_ff <= '0;
         have_last_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_period_ff <= last_period_in;
         have_last_ff   <= have_last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_duty_ff   <= rsp_duty_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_rv_ff     <= rsp_rv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_res_ff, rsp_duty_ff, rsp_freq_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_rv_ff;

   // a new period starts the program
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("program not started for new period");

   // a repeated period leaves the stored period alone
   a_repeat_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && rep_hit) |=> $stable(last_period_ff) && !busy)
      else $error("repeated period disturbed state");

   // no-signal words carry zero measurements
   a_no_signal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NO_SIGNAL) |->
         (rsp_freq_ff == '0 && rsp_duty_ff == '0 && rsp_res_ff == '0 && !rsp_rv_ff))
      else $error("no-signal word with nonzero fields");

   // resistance flag agrees with status
   a_rv_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_rv_ff == ipwm_res_valid(rsp_status_ff)))
      else $error("resistance flag does not match status");

endmodule
